FILE: rtl/u2a_pkg.sv
// Shared types, constants and character helpers for the integer-to-text block.
`default_nettype none
package u2a_pkg;

    localparam int VAL_W    = 64;
    localparam int CHAR_W   = 7;
    localparam int DEC_DIGS = 20;
    localparam int BCD_W    = DEC_DIGS * 4;
    localparam int HEX_DIGS = VAL_W / 4;
    localparam int CNT_W    = $clog2(VAL_W);
    localparam int LEFT_W   = $clog2(DEC_DIGS + 1);

    typedef logic [CHAR_W-1:0] t_char;

    localparam t_char CH_ZERO = 7'h30;
    localparam t_char CH_X    = 7'h78;
    localparam t_char CH_A    = 7'h61;

    localparam logic MODE_DEC = 1'b0;
    localparam logic MODE_HEX = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic dabble;
        logic strip;
        logic emit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic conv_done;
        logic strip_more;
        logic emit_last;
    } t_stat;

    function automatic t_char nib_ascii(input logic [3:0] nib);
        t_char ch;
        if (nib < 4'd10) begin
            ch = CH_ZERO + t_char'(nib);
        end else begin
            ch = CH_A + t_char'(nib - 4'd10);
        end
        return ch;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/u2a_if.sv
// Valid/ready channel interfaces for the input number and the output characters.
`default_nettype none
interface u2a_in_if;
    import u2a_pkg::*;
    logic             valid;
    logic             ready;
    logic             mode;
    logic [VAL_W-1:0] value;
    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface u2a_out_if;
    import u2a_pkg::*;
    logic  valid;
    logic  ready;
    t_char char_code;
    logic  last;
    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/u2a_dpath.sv
// Datapath: value shift register, bit-serial BCD converter and output character register.
`default_nettype none
module u2a_dpath (
    input  wire                   i_clk,
    input  wire                   i_mode,
    input  wire [u2a_pkg::VAL_W-1:0] i_value,
    input  u2a_pkg::t_cmd         i_cmd,
    output u2a_pkg::t_stat        o_stat,
    output u2a_pkg::t_char        o_char,
    output logic                  o_last
);
    import u2a_pkg::*;

    logic              r_mode;
    logic [VAL_W-1:0]  r_bin,  n_bin;
    logic [BCD_W-1:0]  r_bcd,  n_bcd;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;
    logic [LEFT_W-1:0] r_left, n_left;
    logic [1:0]        r_pfx,  n_pfx;
    t_char             r_char, n_char;
    logic              r_last, n_last;
    logic [BCD_W-1:0]  adj;
    logic [3:0]        dig;

    // add-3 on every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < DEC_DIGS; i++) begin
            dig = r_bcd[i*4 +: 4];
            adj[i*4 +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
        end
    end

    always_comb begin
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_left = r_left;
        n_pfx  = r_pfx;
        n_char = r_char;
        n_last = r_last;
        if (i_cmd.load) begin
            n_bin  = i_value;
            n_bcd  = '0;
            n_cnt  = '0;
            n_left = (i_mode == MODE_HEX) ? LEFT_W'(HEX_DIGS) : LEFT_W'(DEC_DIGS);
            n_pfx  = (i_mode == MODE_HEX) ? 2'd2 : 2'd0;
        end else if (i_cmd.dabble) begin
            n_bcd = {adj[BCD_W-2:0], r_bin[VAL_W-1]};
            n_bin = {r_bin[VAL_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
        end else if (i_cmd.strip) begin
            n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
            n_left = r_left - 1'b1;
        end else if (i_cmd.emit) begin
            n_last = o_stat.emit_last;
            if (r_pfx == 2'd2) begin
                n_char = CH_ZERO;
                n_pfx  = 2'd1;
            end else if (r_pfx == 2'd1) begin
                n_char = CH_X;
                n_pfx  = 2'd0;
            end else begin
                n_left = r_left - 1'b1;
                if (r_mode == MODE_HEX) begin
                    n_char = nib_ascii(r_bin[VAL_W-1 -: 4]);
                    n_bin  = {r_bin[VAL_W-5:0], 4'd0};
                end else begin
                    n_char = nib_ascii(r_bcd[BCD_W-1 -: 4]);
                    n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
        end
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_left <= n_left;
        r_pfx  <= n_pfx;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_stat.conv_done  = (r_cnt == CNT_W'(VAL_W - 1));
    assign o_stat.strip_more = (r_bcd[BCD_W-1 -: 4] == 4'd0) && (r_left > LEFT_W'(1));
    assign o_stat.emit_last  = (r_pfx == 2'd0) && (r_left == LEFT_W'(1));
    assign o_char = r_char;
    assign o_last = r_last;

endmodule
`default_nettype wire

FILE: rtl/u2a_ctrl.sv
// Controller: sequences load, conversion, leading-zero skip and character beats.
`default_nettype none
module u2a_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    input  wire            i_in_mode,
    output logic           o_in_ready,
    input  wire            i_out_ready,
    output logic           o_out_valid,
    input  u2a_pkg::t_stat i_stat,
    output u2a_pkg::t_cmd  o_cmd
);
    import u2a_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_STRIP,
        ST_EMIT,
        ST_FLUSH
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   can_load;

    assign o_in_ready = (r_state == ST_IDLE);
    assign can_load   = !r_ovalid || i_out_ready;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_in_mode == MODE_HEX) ? ST_EMIT : ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.dabble = 1'b1;
                if (i_stat.conv_done) begin
                    n_state = ST_STRIP;
                end
            end
            ST_STRIP: begin
                if (i_stat.strip_more) begin
                    o_cmd.strip = 1'b1;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (can_load) begin
                    o_cmd.emit = 1'b1;
                    n_ovalid   = 1'b1;
                    if (i_stat.emit_last) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                // hold the final beat until taken
                if (i_out_ready) begin
                    n_ovalid = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state  = ST_IDLE;
                n_ovalid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_out_valid = r_ovalid;

    a_idle_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !r_ovalid)
        else $error("output beat pending while idle");

    a_flush_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FLUSH |-> r_ovalid)
        else $error("final beat missing in flush");

    a_conv_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV && i_stat.conv_done) |=> r_state == ST_STRIP)
        else $error("conversion did not end after all bits");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.dabble, o_cmd.strip, o_cmd.emit}))
        else $error("conflicting datapath commands");

endmodule
`default_nettype wire

FILE: rtl/u64_to_ascii_dec_hex.sv
// Top level: unsigned 64-bit value to ASCII decimal or 0x-prefixed hex text.
// Hex: accept moves straight to the emit state; 18 beats (0, x, 16 digits) at one per cycle
// while the output is not stalled. Decimal: bit-serial double-dabble over all 64 input bits, then
// leading-zero skip and digit beats; skipped digits plus digit beats always total 20.
// One item at a time; output stalls hold the beats; a new item is taken after the last beat leaves.
// Synchronous active-low reset clears the controller; no state is kept between items.
`default_nettype none
module u64_to_ascii_dec_hex (
    input  wire        i_clk,
    input  wire        i_rst_n,
    u2a_in_if.sink     i_in,
    u2a_out_if.source  o_out
);
    import u2a_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;
    logic  out_valid;
    t_char ch;
    logic  last;

    u2a_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_mode   (i_in.mode),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    u2a_dpath u_dpath (
        .i_clk   (i_clk),
        .i_mode  (i_in.mode),
        .i_value (i_in.value),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_char  (ch),
        .o_last  (last)
    );

    assign i_in.ready      = in_ready;
    assign o_out.valid     = out_valid;
    assign o_out.char_code = ch;
    assign o_out.last      = last;

endmodule
`default_nettype wire

FILE: bench/u2a_text_checker.sv
// Checker for the integer-to-text block: predicts each character run and compares it beat by beat.
`default_nettype none
module u2a_text_checker
    import u2a_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_num_valid,
    input  logic             i_num_ready,
    input  logic             i_num_mode,
    input  logic [VAL_W-1:0] i_num_value,
    input  logic             i_txt_valid,
    input  logic             i_txt_ready,
    input  t_char            i_txt_char,
    input  logic             i_txt_last,
    output int               o_fail_count,
    output int               o_chars_pending
);

    localparam string HEX_GLYPHS = "0123456789abcdef";

    typedef struct {
        t_char code;
        logic  last;
    } t_text_char;

    t_text_char expected_chars[$];
    int         mismatches = 0;
    int         pending    = 0;

    assign o_fail_count    = mismatches;
    assign o_chars_pending = pending;

    // Appends the text form of one number to the expected character queue.
    function automatic void queue_text_of(input logic mode, input logic [VAL_W-1:0] value);
        logic [VAL_W-1:0] rest;
        t_char            digits[$];
        logic [3:0]       nib;
        t_text_char       ch;
        if (mode == MODE_HEX) begin
            ch.last = 1'b0;
            ch.code = CH_ZERO;
            expected_chars.push_back(ch);
            ch.code = CH_X;
            expected_chars.push_back(ch);
            for (int k = HEX_DIGS - 1; k >= 0; k--) begin
                nib     = value[k*4 +: 4];
                ch.code = t_char'(HEX_GLYPHS[nib]);
                ch.last = (k == 0);
                expected_chars.push_back(ch);
            end
        end else begin
            // zero still gives one digit
            rest = value;
            do begin
                digits.push_front(CH_ZERO + t_char'(rest % 64'd10));
                rest = rest / 64'd10;
            end while (rest != '0);
            foreach (digits[i]) begin
                ch.code = digits[i];
                ch.last = (i == digits.size() - 1);
                expected_chars.push_back(ch);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n) begin
            if (i_txt_valid && i_txt_ready) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected beat: char_code=%h last=%b", i_txt_char, i_txt_last);
                    mismatches = mismatches + 1;
                end else begin
                    want = expected_chars.pop_front();
                    if (i_txt_char !== want.code) begin
                        $error("char_code mismatch: expected %h, got %h", want.code, i_txt_char);
                        mismatches = mismatches + 1;
                    end
                    if (i_txt_last !== want.last) begin
                        $error("last mismatch: expected %b, got %b", want.last, i_txt_last);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (i_num_valid && i_num_ready) begin
                queue_text_of(i_num_mode, i_num_value);
            end
            pending = expected_chars.size();
        end
    end

endmodule
`default_nettype wire

FILE: bench/u64_to_ascii_dec_hex_tb.sv
// Testbench top: drives numbers into the integer-to-text block and gives the verdict.
`default_nettype none
module u64_to_ascii_dec_hex_tb;
    import u2a_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int RAND_NUMS   = 200;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic no_idle = 1'b0;
    int   fail_count;
    int   chars_pending;
    int   stall_cycles = 0;

    u2a_in_if  num_ch ();
    u2a_out_if text_ch ();

    u64_to_ascii_dec_hex u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (num_ch),
        .o_out   (text_ch)
    );

    u2a_text_checker u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_num_valid     (num_ch.valid),
        .i_num_ready     (num_ch.ready),
        .i_num_mode      (num_ch.mode),
        .i_num_value     (num_ch.value),
        .i_txt_valid     (text_ch.valid),
        .i_txt_ready     (text_ch.ready),
        .i_txt_char      (text_ch.char_code),
        .i_txt_last      (text_ch.last),
        .o_fail_count    (fail_count),
        .o_chars_pending (chars_pending)
    );

    always #4 clk = ~clk;

    // character sink backpressure
    always @(negedge clk) begin
        text_ch.ready = no_idle || ($urandom_range(0, 99) >= 9);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((num_ch.valid && num_ch.ready) || (text_ch.valid && text_ch.ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles = stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Enters just after an accepting edge (or after reset), leaves on the accepting edge.
    task automatic send_number(input logic mode, input logic [VAL_W-1:0] value);
        int gap;
        @(negedge clk);
        if (!no_idle && $urandom_range(0, 99) < 9) begin
            gap           = $urandom_range(1, 4);
            num_ch.valid  = 1'b0;
            num_ch.mode   = 1'($urandom_range(0, 1));
            num_ch.value  = {$urandom, $urandom};
            repeat (gap) @(negedge clk);
        end
        num_ch.valid = 1'b1;
        num_ch.mode  = mode;
        num_ch.value = value;
        do @(posedge clk); while (!num_ch.ready);
    endtask

    initial begin
        logic [VAL_W-1:0] v;
        logic [VAL_W-1:0] p;
        logic             m;
        num_ch.valid  = 1'b0;
        num_ch.mode   = MODE_DEC;
        num_ch.value  = '0;
        text_ch.ready = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // decimal corners: zero, digit-count boundaries, 19 and 20 digit runs
        send_number(MODE_DEC, 64'd0);
        send_number(MODE_DEC, 64'd1);
        send_number(MODE_DEC, 64'd9);
        send_number(MODE_DEC, 64'd10);
        send_number(MODE_DEC, 64'd99);
        send_number(MODE_DEC, 64'd100);
        send_number(MODE_DEC, 64'h7FFF_FFFF_FFFF_FFFF);
        send_number(MODE_DEC, 64'h8000_0000_0000_0000);
        send_number(MODE_DEC, 64'h8AC7_2304_89E7_FFFF);
        send_number(MODE_DEC, 64'h8AC7_2304_89E8_0000);
        send_number(MODE_DEC, 64'hFFFF_FFFF_FFFF_FFFE);
        send_number(MODE_DEC, 64'hFFFF_FFFF_FFFF_FFFF);
        // hex: every glyph, all zeros, all ones, top bit alone
        send_number(MODE_HEX, 64'd0);
        send_number(MODE_HEX, 64'hFFFF_FFFF_FFFF_FFFF);
        send_number(MODE_HEX, 64'h0123_4567_89AB_CDEF);
        send_number(MODE_HEX, 64'hFEDC_BA98_7654_3210);
        send_number(MODE_HEX, 64'h8000_0000_0000_0000);
        send_number(MODE_HEX, 64'd1);

        for (int i = 0; i < RAND_NUMS; i++) begin
            no_idle = (i >= 80 && i < 140);
            m = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 4))
                0: v = {$urandom, $urandom};
                1: v = VAL_W'($urandom_range(0, 999));
                2: v = {$urandom, $urandom} >> $urandom_range(0, 63);
                3: begin
                    // around a power of ten
                    p = 64'd1;
                    repeat ($urandom_range(0, 19)) p = p * 64'd10;
                    v = p + VAL_W'($urandom_range(0, 2)) - 64'd1;
                end
                default: begin
                    v = 64'd1 << $urandom_range(0, 63);
                    if ($urandom_range(0, 1) == 1) v = ~v;
                end
            endcase
            send_number(m, v);
        end
        no_idle = 1'b0;
        @(negedge clk);
        num_ch.valid = 1'b0;

        while (chars_pending != 0) @(negedge clk);
        repeat (120) @(negedge clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire
